// File: hw/rtl/raw_stream_resampler_macros.svh
// Assertion macros for the resampler checker.
`ifndef RAW_STREAM_RESAMPLER_MACROS_SVH
`define RAW_STREAM_RESAMPLER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define RSR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, with the consequent checked in the cycle after the antecedent.
`define RSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/rsr_pkg.sv
// Types and constants for the raw stream resampler.
package rsr_pkg;

	localparam int RING_DEPTH_DEF = 8192;
	localparam int CFG_DATA_W     = 23;

	localparam logic [23:0] ONE_Q16  = 24'h01_0000;
	localparam logic [22:0] MIN_STEP = 23'd1024;
	localparam logic [8:0]  VOL_MAX  = 9'd256;
	localparam logic signed [16:0] CODE_BIAS = 17'sd128;

	typedef enum logic [1:0] {
		CFG_STEP     = 2'd0,
		CFG_WIDTH    = 2'd1,
		CFG_CHANNELS = 2'd2,
		CFG_VOLUME   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] sample_left;
		logic [15:0] sample_right;
		logic [30:0] mix_time;
		logic        last_frame;
	} in_word_t;

	typedef struct packed {
		logic [12:0]        ring_index;
		logic signed [23:0] left_out;
		logic signed [23:0] right_out;
		logic               last_of_run;
	} out_word_t;

endpackage

// File: hw/rtl/raw_stream_resampler.sv
// Nearest-neighbor resampler: one source frame in, up to 64 scaled stereo pairs out.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------
//  in      | to block  | in_valid / in_stall | in_word  (in_word_t)
//  out     | from block| out_valid/out_stall | out_word (out_word_t)
//  cfg     | to block  | cfg_we              | cfg_index, cfg_data
//
// A frame passes S_MUL_L, S_MUL_R, then S_EMIT for its pairs; the first frame of
// a chunk also passes S_CLAMP, S_RECIP, S_REM and S_FIX (clamp, reciprocal
// multiply, remainder, correction). The shared 17x10 multiplier scales left then
// right; pairs leave one per cycle unless a waiting out_word is stalled. in_stall
// drops when S_EMIT returns to S_IDLE after the last pair. arst_n resets all state.
module raw_stream_resampler
	import rsr_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_word_t              in_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_word_t             out_word,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = $clog2(RING_DEPTH);
	localparam int RW = IW + 1;
	localparam logic [31:0] RECIP_M = 32'((64'd1 << 32) / 64'(RING_DEPTH));

	typedef enum logic [2:0] {
		S_IDLE, S_MUL_L, S_MUL_R, S_CLAMP, S_RECIP, S_REM, S_FIX, S_EMIT
	} state_t;

	state_t             state_q;
	logic [22:0]        step_ratio_q;
	logic               width_q;
	logic               chan_q;
	logic [8:0]         vol_q;
	logic [31:0]        wp_q;
	logic [23:0]        phase_q;
	logic               chunk_q;
	logic [IW-1:0]      ring_q;
	logic [63:0]        recip_prod_q;
	logic [RW-1:0]      rem_q;
	in_word_t           in_q;
	logic signed [23:0] left_q;
	logic signed [23:0] right_q;
	out_word_t          out_q;
	logic               out_valid_q;

	logic [22:0]        step_eff;
	logic [8:0]         vol_eff;
	logic [15:0]        mul_code;
	logic signed [16:0] mul_a;
	logic signed [9:0]  mul_b;
	logic signed [26:0] mul_p;
	logic signed [23:0] scaled;
	logic [23:0]        phase_sum;
	logic               emit_ok;
	logic               emit_go;
	logic [31:0]        quot;
	logic [31:0]        slot_raw;
	logic [IW-1:0]      rem_fix;
	logic [IW-1:0]      ring_inc;
	logic [31:0]        ring_ext;

	assign step_eff = (step_ratio_q < MIN_STEP) ? MIN_STEP : step_ratio_q;
	assign vol_eff  = (vol_q > VOL_MAX) ? VOL_MAX : vol_q;

	// shared multiplier: left in S_MUL_L, right in S_MUL_R
	assign mul_code = (state_q == S_MUL_L) ? in_q.sample_left : in_q.sample_right;
	assign mul_a    = width_q ? 17'($signed(mul_code))
	                          : $signed({9'd0, mul_code[7:0]}) - CODE_BIAS;
	assign mul_b    = $signed({1'b0, vol_eff});
	assign mul_p    = mul_a * mul_b;
	// 8-bit codes get the extra x256
	assign scaled   = width_q ? mul_p[23:0] : {mul_p[15:0], 8'd0};

	assign phase_sum = phase_q + 24'(step_eff);
	assign emit_ok   = !out_valid_q || !out_stall;
	assign emit_go   = (state_q == S_EMIT) && (phase_q < ONE_Q16) && emit_ok;

	// ring slot by reciprocal: quotient is exact or one short, so one correction
	assign quot      = recip_prod_q[63:32];
	assign slot_raw  = wp_q - quot * 32'(RING_DEPTH);
	assign rem_fix   = (rem_q >= RW'(RING_DEPTH)) ? IW'(rem_q - RW'(RING_DEPTH))
	                                              : rem_q[IW-1:0];
	assign ring_inc  = (wp_q == '1 || ring_q == IW'(RING_DEPTH - 1)) ? '0
	                                                                 : ring_q + 1'b1;
	assign ring_ext  = 32'(ring_q);

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_ratio_q <= 23'd65536;
			width_q      <= 1'b1;
			chan_q       <= 1'b1;
			vol_q        <= VOL_MAX;
			wp_q         <= '0;
			phase_q      <= '0;
			chunk_q      <= 1'b1;
			ring_q       <= '0;
			recip_prod_q <= '0;
			rem_q        <= '0;
			in_q         <= '0;
			left_q       <= '0;
			right_q      <= '0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_STEP:     step_ratio_q <= cfg_data;
					CFG_WIDTH:    width_q      <= cfg_data[0];
					CFG_CHANNELS: chan_q       <= cfg_data[0];
					CFG_VOLUME:   vol_q        <= cfg_data[8:0];
					default:      ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_q    <= in_word;
						state_q <= S_MUL_L;
					end
				end
				S_MUL_L: begin
					left_q  <= scaled;
					state_q <= S_MUL_R;
				end
				S_MUL_R: begin
					right_q <= chan_q ? scaled : left_q;
					state_q <= chunk_q ? S_CLAMP : S_EMIT;
				end
				S_CLAMP: begin
					if (wp_q < {1'b0, in_q.mix_time}) begin
						wp_q <= {1'b0, in_q.mix_time};
					end
					phase_q <= '0;
					state_q <= S_RECIP;
				end
				S_RECIP: begin
					recip_prod_q <= 64'(wp_q) * 64'(RECIP_M);
					state_q      <= S_REM;
				end
				S_REM: begin
					rem_q   <= slot_raw[RW-1:0];
					state_q <= S_FIX;
				end
				S_FIX: begin
					ring_q  <= rem_fix;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (phase_q < ONE_Q16) begin
						if (emit_go) begin
							out_q.ring_index  <= ring_ext[12:0];
							out_q.left_out    <= left_q;
							out_q.right_out   <= right_q;
							out_q.last_of_run <= (phase_sum >= ONE_Q16);
							wp_q              <= wp_q + 32'd1;
							ring_q            <= ring_inc;
							phase_q           <= phase_sum;
						end
					end else begin
						phase_q <= in_q.last_frame ? '0 : phase_q - ONE_Q16;
						chunk_q <= in_q.last_frame;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/rsr_checker.sv
// Port-level checker for the raw stream resampler, bound to the top level.
`include "raw_stream_resampler_macros.svh"

module rsr_checker
	import rsr_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input in_word_t              in_word,
	input logic                  out_valid,
	input logic                  out_stall,
	input out_word_t             out_word
);

	// a held output word stays put
	`RSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, $stable({out_valid, out_word}), "word moved")
	// a stalled input word stays put
	`RSR_ASSERT_NEXT(a_in_hold, in_valid && in_stall, $stable({in_valid, in_word}), "input moved")
	// one frame at a time
	`RSR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "busy after accept")
	// when ready again, any pending pair is the close of a run
	`RSR_ASSERT(a_idle_pending_last, !in_stall && out_valid |-> out_word.last_of_run, "open run")

endmodule

bind raw_stream_resampler rsr_checker u_rsr_checker (.*);

// File: tb/sv/tb_top.sv
// Testbench for raw_stream_resampler: self-predicting pair checker under random flow control.
`timescale 1ns / 1ps

module tb_top;
	import rsr_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_CYCLES = 64;
	localparam int PHASE_ITEMS  = 38;
	localparam logic [31:0] MIX_TOP = 32'h4000_0000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_word_t              in_word;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_word_t             out_word;
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor copy of the registers and of the running state
	logic [22:0] cfg_step;
	logic        cfg_wide;
	logic        cfg_stereo;
	logic [8:0]  cfg_vol;
	logic [31:0] wr_ptr;
	logic [23:0] acc_phase;
	logic        at_chunk_start;

	out_word_t expected_pairs[$];
	out_word_t want;
	int        mismatch_count = 0;
	int        cycle_count = 0;
	int        in_idle_pct = 0;
	int        out_stall_pct = 0;
	int        hold_req = 0;
	int        hold_seen = 0;
	int        hold_left = 0;

	raw_stream_resampler u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Output stall: random per cycle, or a long hold when a test asks for one
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < out_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pairs.size() == 0) begin
				$error("unexpected output word: ring_index %0d left %0d right %0d",
					out_word.ring_index, out_word.left_out, out_word.right_out);
				mismatch_count++;
			end else begin
				want = expected_pairs.pop_front();
				if (out_word.ring_index !== want.ring_index) begin
					$error("ring_index: expected %0d, got %0d",
						want.ring_index, out_word.ring_index);
					mismatch_count++;
				end
				if (out_word.left_out !== want.left_out) begin
					$error("left_out: expected %0d, got %0d", want.left_out, out_word.left_out);
					mismatch_count++;
				end
				if (out_word.right_out !== want.right_out) begin
					$error("right_out: expected %0d, got %0d",
						want.right_out, out_word.right_out);
					mismatch_count++;
				end
				if (out_word.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %0b, got %0b",
						want.last_of_run, out_word.last_of_run);
					mismatch_count++;
				end
			end
		end
	end

	function automatic logic [23:0] scale_sample(logic [15:0] code);
		int                 vol;
		int                 s;
		logic signed [15:0] c16;
		vol = (cfg_vol > VOL_MAX) ? int'(VOL_MAX) : int'(cfg_vol);
		c16 = code;
		if (cfg_wide)
			s = int'(c16) * vol;
		else
			s = (int'(code[7:0]) - 128) * vol * 256;
		return s[23:0];
	endfunction

	// Expected pairs for one accepted source frame
	function automatic void resample_frame(in_word_t w);
		logic [31:0] step;
		logic [31:0] ph;
		logic [23:0] l;
		logic [23:0] r;
		out_word_t   p;
		step = (cfg_step < MIN_STEP) ? 32'(MIN_STEP) : 32'(cfg_step);
		if (at_chunk_start) begin
			if (wr_ptr < 32'(w.mix_time))
				wr_ptr = 32'(w.mix_time);
			acc_phase = '0;
		end
		l = scale_sample(w.sample_left);
		r = cfg_stereo ? scale_sample(w.sample_right) : l;
		ph = 32'(acc_phase);
		while (ph < 32'(ONE_Q16)) begin
			p.ring_index = 13'(wr_ptr % 32'(RING_DEPTH_DEF));
			p.left_out = l;
			p.right_out = r;
			wr_ptr = wr_ptr + 1;
			ph = ph + step;
			p.last_of_run = (ph >= 32'(ONE_Q16));
			expected_pairs.push_back(p);
		end
		acc_phase = 24'(ph - 32'(ONE_Q16));
		if (w.last_frame) begin
			acc_phase = '0;
			at_chunk_start = 1'b1;
		end else begin
			at_chunk_start = 1'b0;
		end
	endfunction

	task automatic send_frame(in_word_t w);
		int gap;
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		resample_frame(w);
		gap = 0;
		while ($urandom_range(0, 99) < in_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [22:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_STEP:     cfg_step = val;
			CFG_WIDTH:    cfg_wide = val[0];
			CFG_CHANNELS: cfg_stereo = val[0];
			CFG_VOLUME:   cfg_vol = val[8:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(logic [22:0] step, bit wide, bit stereo, logic [8:0] vol);
		write_reg(CFG_STEP, step);
		write_reg(CFG_WIDTH, 23'(wide));
		write_reg(CFG_CHANNELS, 23'(stereo));
		write_reg(CFG_VOLUME, 23'(vol));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every expected pair, then let a frame with no pairs finish too
	task automatic drain(int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_pairs.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	function automatic in_word_t make_frame(logic [15:0] l, logic [15:0] r,
		logic [31:0] mt, bit last);
		in_word_t w;
		w.sample_left = l;
		w.sample_right = r;
		w.mix_time = mt[30:0];
		w.last_frame = last;
		return w;
	endfunction

	function automatic logic [31:0] pick_mix_time();
		logic [31:0] mt;
		case ($urandom_range(0, 3))
			0: mt = $urandom_range(0, MIX_TOP);
			1: mt = wr_ptr + $urandom_range(0, 5000);
			2: mt = (wr_ptr > 32'd3000) ? wr_ptr - $urandom_range(0, 3000) : 32'd0;
			default: mt = 32'd0;
		endcase
		return (mt > MIX_TOP) ? MIX_TOP : mt;
	endfunction

	// Power-on registers: 16-bit stereo, unity step and gain, sample extremes
	task automatic test_reset_defaults();
		send_frame(make_frame(16'h7FFF, 16'h8000, 32'd0, 1'b0));
		send_frame(make_frame(16'h8000, 16'h7FFF, 32'd12345, 1'b0));
		send_frame(make_frame(16'hFFFF, 16'h0000, 32'd99, 1'b1));
		// chunk start clamps the slot forward to the mixer time
		send_frame(make_frame(16'h0001, 16'hFFFE, MIX_TOP, 1'b0));
		send_frame(make_frame(16'h5555, 16'hAAAA, 32'd0, 1'b1));
		// mixer time behind the slot leaves it alone
		send_frame(make_frame(16'h1234, 16'hEDCB, 32'd7, 1'b1));
		drain(SETTLE_CYCLES);
	endtask

	// Step below the minimum and gain above unity are both clamped
	task automatic test_clamped_registers();
		configure(23'd0, 1'b0, 1'b0, 9'd511);
		send_frame(make_frame(16'hFF00, 16'h1234, 32'd20, 1'b0));
		send_frame(make_frame(16'h00FF, 16'hFFFF, 32'd0, 1'b0));
		send_frame(make_frame(16'hAB80, 16'h0000, 32'd0, 1'b1));
		drain(SETTLE_CYCLES);
		configure(23'd1024, 1'b1, 1'b0, 9'd0);
		send_frame(make_frame(16'h7FFF, 16'h8000, 32'd0, 1'b0));
		send_frame(make_frame(16'h8000, 16'h7FFF, 32'd0, 1'b1));
		drain(SETTLE_CYCLES);
		configure(23'd98304, 1'b0, 1'b1, 9'd256);
		send_frame(make_frame(16'h0000, 16'h00FF, 32'd0, 1'b0));
		send_frame(make_frame(16'h007F, 16'h0080, 32'd0, 1'b0));
		send_frame(make_frame(16'hFF01, 16'h00FE, 32'd0, 1'b1));
		drain(SETTLE_CYCLES);
	endtask

	// Large step: most frames produce nothing, chunk end cuts the run
	task automatic test_sparse_output();
		configure(23'd4194304, 1'b1, 1'b1, 9'd128);
		for (int i = 0; i < 6; i++)
			send_frame(make_frame(16'($urandom), 16'($urandom), 32'd5, i == 5));
		drain(SETTLE_CYCLES);
	endtask

	// Receiver holds off while frames keep coming, so the input backs up
	task automatic test_output_hold();
		configure(23'd16384, 1'b1, 1'b1, 9'd200);
		in_idle_pct = 0;
		out_stall_pct = 0;
		hold_req++;
		for (int i = 0; i < 24; i++)
			send_frame(make_frame(16'($urandom), 16'($urandom), pick_mix_time(),
				i % 8 == 7));
		drain(SETTLE_CYCLES);
	endtask

	task automatic random_phase_config();
		logic [22:0] step;
		case ($urandom_range(0, 4))
			0: step = 23'($urandom_range(1024, 16384));
			1: step = 23'($urandom_range(16384, 131072));
			2: step = 23'd65536;
			3: step = 23'($urandom_range(131072, 1048576));
			default: step = 23'($urandom_range(1048576, 4194304));
		endcase
		configure(step, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			9'($urandom_range(0, 256)));
	endtask

	// Mostly well-formed chunks with random content, some frames with random chunk ends
	task automatic test_random_chunks();
		int sent;
		int len;
		for (int ph = 0; ph < 8; ph++) begin
			random_phase_config();
			case (ph % 4)
				0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
				1: begin in_idle_pct = 84; out_stall_pct = 0;  end
				2: begin in_idle_pct = 0;  out_stall_pct = 84; end
				default: begin in_idle_pct = 14; out_stall_pct = 14; end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					send_frame(make_frame(16'($urandom), 16'($urandom), pick_mix_time(),
						1'($urandom_range(0, 1))));
					sent++;
				end else begin
					len = $urandom_range(1, 8);
					for (int i = 0; i < len; i++)
						send_frame(make_frame(16'($urandom), 16'($urandom),
							pick_mix_time(), i == len - 1));
					sent += len;
				end
			end
			drain(SETTLE_CYCLES);
		end
		in_idle_pct = 0;
		out_stall_pct = 0;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_word <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_STEP;
		cfg_data <= '0;
		cfg_step = 23'd65536;
		cfg_wide = 1'b1;
		cfg_stereo = 1'b1;
		cfg_vol = 9'd256;
		wr_ptr = '0;
		acc_phase = '0;
		at_chunk_start = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_clamped_registers();
		test_sparse_output();
		test_output_hold();
		test_random_chunks();
		drain(100);
		if (mismatch_count == 0 && expected_pairs.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
